// ----- design/rbnh_pkg.sv -----
// Shared types and constants for the ray/box nearest-hit core.
// Used by ray_box_nearest_hit_core; depends on nothing else.
package rbnh_pkg;

	localparam int DIR_W   = 16;
	localparam int DIR_FRAC = 14;
	localparam int HALF_W  = 15;
	localparam int DIST_W  = 16;
	localparam int COLOR_W = 8;
	localparam int COUNT_W = 4;
	localparam int SLOT_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DVS_W   = 16;
	localparam int REM_W   = 17;

	localparam logic [COUNT_W-1:0] COUNT_RST = 4'd0;
	localparam logic [HALF_W-1:0]  HALF_RST  = 15'd128;
	localparam logic [DIST_W-1:0]  DIST_RST  = 16'd25600;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TRACE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_COUNT = 2'd0,
		REG_HALF_SIZE = 2'd1,
		REG_MAX_DIST  = 2'd2,
		REG_UNUSED    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2,
		AX_NONE = 2'd3
	} axis_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_AXIS  = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_FIX   = 7'b0010000,
		S_EVAL  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

endpackage

// ----- design/ray_box_nearest_hit_core.sv -----
// Ray/box nearest-hit core: cube table, sequencer and one shared serial divider.
// Depends on rbnh_pkg.
// A write beat leaves busy low. A trace beat keeps busy high while it visits the
// first n = min(box_count, MAX_CUBES) cubes, with two divisions on each axis whose
// direction is nonzero; an axis with a zero direction skips the divider. The serial
// divider gives one quotient bit per cycle. The result strobe follows and the
// receiver cannot stall it.
// arst_n clears control state and configuration; the cube table is not cleared.
module ray_box_nearest_hit_core #(
	parameter int MAX_CUBES  = 8,
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic operation,
	input  logic [rbnh_pkg::SLOT_W-1:0] entry_index,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic signed [rbnh_pkg::DIR_W-1:0] dir_x,
	input  logic signed [rbnh_pkg::DIR_W-1:0] dir_y,
	input  logic signed [rbnh_pkg::DIR_W-1:0] dir_z,
	input  logic [rbnh_pkg::COLOR_W-1:0] paint_red,
	input  logic [rbnh_pkg::COLOR_W-1:0] paint_green,
	input  logic [rbnh_pkg::COLOR_W-1:0] paint_blue,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rbnh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbnh_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic result_valid,
	output logic hit,
	output logic [rbnh_pkg::SLOT_W-1:0] hit_index,
	output logic [rbnh_pkg::DIST_W-1:0] hit_distance,
	output logic [rbnh_pkg::COLOR_W-1:0] shade_red,
	output logic [rbnh_pkg::COLOR_W-1:0] shade_green,
	output logic [rbnh_pkg::COLOR_W-1:0] shade_blue
);

	localparam int IDX_W  = (MAX_CUBES > 1) ? $clog2(MAX_CUBES) : 1;
	localparam int CNT_W  = (IDX_W + 1 > rbnh_pkg::COUNT_W) ? IDX_W + 1 : rbnh_pkg::COUNT_W;
	localparam int NUM_W  = ((COORD_BITS + 1 > rbnh_pkg::DIST_W) ?
		COORD_BITS + 1 : rbnh_pkg::DIST_W) + 1;
	localparam int DVD_W  = NUM_W + rbnh_pkg::DIR_FRAC;
	localparam int T_W    = DVD_W + 1;
	localparam int STEP_W = $clog2(DVD_W + 1);
	localparam int CTR_W  = 3 * COORD_BITS;
	localparam int COL_W  = 3 * rbnh_pkg::COLOR_W;

	rbnh_pkg::state_t state_q;

	logic [rbnh_pkg::COUNT_W-1:0] box_count_q;
	logic [rbnh_pkg::HALF_W-1:0]  half_q;
	logic [rbnh_pkg::DIST_W-1:0]  max_dist_q;

	logic [CTR_W-1:0] ctr_mem [MAX_CUBES];
	logic [COL_W-1:0] col_mem [MAX_CUBES];
	logic [CTR_W-1:0] rd_ctr_q;
	logic [COL_W-1:0] rd_col_q;

	logic signed [COORD_BITS-1:0] org_q [3];
	logic signed [rbnh_pkg::DIR_W-1:0] dir_q [3];

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [1:0] ax_q;
	logic sel_q;
	logic have_q;
	logic signed [T_W-1:0] lo_q;
	logic signed [T_W-1:0] tn_q;
	logic signed [T_W-1:0] tf_q;
	logic signed [NUM_W-1:0] num_hi_q;

	logic [DVD_W-1:0] dvd_q;
	logic [rbnh_pkg::DVS_W-1:0] dvs_q;
	logic [rbnh_pkg::REM_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic neg_q;

	logic [rbnh_pkg::DIST_W-1:0] best_q;
	logic best_hit_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [COL_W-1:0] best_col_q;

	logic res_valid_q;
	logic res_hit_q;
	logic [rbnh_pkg::SLOT_W-1:0] res_idx_q;
	logic [rbnh_pkg::DIST_W-1:0] res_dist_q;
	logic [COL_W-1:0] res_col_q;

	logic accept;
	logic [CNT_W-1:0] wr_slot;
	logic [CNT_W-1:0] n_eff;
	logic signed [COORD_BITS-1:0] p_ax;
	logic signed [COORD_BITS-1:0] c_ax;
	logic signed [rbnh_pkg::DIR_W-1:0] d_ax;
	logic signed [NUM_W-1:0] o_ax;
	logic signed [NUM_W-1:0] h_s;
	logic signed [NUM_W-1:0] num_lo;
	logic signed [NUM_W-1:0] num_hi;
	logic par_pass;
	logic [NUM_W-1:0] lo_mag;
	logic [NUM_W-1:0] hi_mag;
	logic [rbnh_pkg::DIR_W-1:0] d_neg;
	logic [rbnh_pkg::REM_W-1:0] trial;
	logic trial_ge;
	logic signed [T_W-1:0] q_val;
	logic signed [T_W-1:0] t_val;
	logic signed [T_W-1:0] tn_new;
	logic signed [T_W-1:0] tf_new;
	logic signed [T_W-1:0] best_ext;
	logic cube_ok;

	assign accept    = start && !busy;
	assign busy      = (state_q != rbnh_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign wr_slot   = CNT_W'(entry_index);
	assign n_eff     = (CNT_W'(box_count_q) > CNT_W'(MAX_CUBES)) ?
		CNT_W'(MAX_CUBES) : CNT_W'(box_count_q);

	always_comb begin
		case (ax_q)
			rbnh_pkg::AX_X: begin
				p_ax = org_q[0];
				c_ax = rd_ctr_q[0 +: COORD_BITS];
				d_ax = dir_q[0];
			end
			rbnh_pkg::AX_Y: begin
				p_ax = org_q[1];
				c_ax = rd_ctr_q[COORD_BITS +: COORD_BITS];
				d_ax = dir_q[1];
			end
			default: begin
				p_ax = org_q[2];
				c_ax = rd_ctr_q[2*COORD_BITS +: COORD_BITS];
				d_ax = dir_q[2];
			end
		endcase
	end

	always_comb begin
		o_ax     = NUM_W'(p_ax) - NUM_W'(c_ax);
		h_s      = signed'(NUM_W'(half_q));
		par_pass = (o_ax >= -h_s) && (o_ax <= h_s);
		num_lo   = d_ax[rbnh_pkg::DIR_W-1] ? (h_s - o_ax) : (-o_ax - h_s);
		num_hi   = d_ax[rbnh_pkg::DIR_W-1] ? (-o_ax - h_s) : (h_s - o_ax);
		lo_mag   = num_lo[NUM_W-1] ? NUM_W'(-num_lo) : NUM_W'(num_lo);
		hi_mag   = num_hi_q[NUM_W-1] ? NUM_W'(-num_hi_q) : NUM_W'(num_hi_q);
		d_neg    = d_ax[rbnh_pkg::DIR_W-1] ? rbnh_pkg::DIR_W'(-d_ax) : rbnh_pkg::DIR_W'(d_ax);
	end

	always_comb begin
		trial    = {rem_q[rbnh_pkg::DVS_W-1:0], dvd_q[DVD_W-1]};
		trial_ge = (trial >= {1'b0, dvs_q});
		q_val    = signed'(T_W'(dvd_q));
		t_val    = neg_q ? ((rem_q != '0) ? ~q_val : -q_val) : q_val;
		tn_new   = (!have_q || (lo_q > tn_q)) ? lo_q : tn_q;
		tf_new   = (!have_q || (t_val < tf_q)) ? t_val : tf_q;
		best_ext = signed'(T_W'(best_q));
		cube_ok  = have_q && !(tn_q > tf_q) && !(tf_q < 0) && (tn_q > 0) && (tn_q < best_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= rbnh_pkg::COUNT_RST;
			half_q      <= rbnh_pkg::HALF_RST;
			max_dist_q  <= rbnh_pkg::DIST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rbnh_pkg::REG_BOX_COUNT: box_count_q <= cfg_data[rbnh_pkg::COUNT_W-1:0];
				rbnh_pkg::REG_HALF_SIZE: half_q <= cfg_data[rbnh_pkg::HALF_W-1:0];
				rbnh_pkg::REG_MAX_DIST:  max_dist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (operation == rbnh_pkg::OP_WRITE) && (wr_slot < CNT_W'(MAX_CUBES))) begin
			ctr_mem[wr_slot[IDX_W-1:0]] <= {point_z, point_y, point_x};
			col_mem[wr_slot[IDX_W-1:0]] <= {paint_blue, paint_green, paint_red};
		end
		if (state_q == rbnh_pkg::S_FETCH) begin
			rd_ctr_q <= ctr_mem[cnt_q[IDX_W-1:0]];
			rd_col_q <= col_mem[cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbnh_pkg::S_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			n_q         <= '0;
			ax_q        <= rbnh_pkg::AX_X;
			sel_q       <= 1'b0;
			have_q      <= 1'b0;
			step_q      <= '0;
			best_hit_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				rbnh_pkg::S_IDLE: begin
					if (accept && (operation == rbnh_pkg::OP_TRACE)) begin
						org_q[0]   <= point_x;
						org_q[1]   <= point_y;
						org_q[2]   <= point_z;
						dir_q[0]   <= dir_x;
						dir_q[1]   <= dir_y;
						dir_q[2]   <= dir_z;
						best_q     <= max_dist_q;
						best_hit_q <= 1'b0;
						best_idx_q <= '0;
						cnt_q      <= '0;
						n_q        <= n_eff;
						state_q    <= (n_eff == '0) ? rbnh_pkg::S_DONE : rbnh_pkg::S_FETCH;
					end
				end
				rbnh_pkg::S_FETCH: begin
					ax_q    <= rbnh_pkg::AX_X;
					have_q  <= 1'b0;
					state_q <= rbnh_pkg::S_AXIS;
				end
				rbnh_pkg::S_AXIS: begin
					if (d_ax == '0) begin
						if (!par_pass) begin
							state_q <= rbnh_pkg::S_EVAL;
							have_q  <= 1'b0;
							ax_q    <= rbnh_pkg::AX_X;
						end else if (ax_q == rbnh_pkg::AX_Z) begin
							state_q <= rbnh_pkg::S_EVAL;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end else begin
						dvd_q    <= {lo_mag, rbnh_pkg::DIR_FRAC'(0)};
						dvs_q    <= d_neg[rbnh_pkg::DVS_W-1:0];
						neg_q    <= num_lo[NUM_W-1] ^ d_ax[rbnh_pkg::DIR_W-1];
						num_hi_q <= num_hi;
						rem_q    <= '0;
						step_q   <= '0;
						sel_q    <= 1'b0;
						state_q  <= rbnh_pkg::S_DIV;
					end
				end
				rbnh_pkg::S_DIV: begin
					rem_q  <= trial_ge ? (trial - {1'b0, dvs_q}) : trial;
					dvd_q  <= {dvd_q[DVD_W-2:0], trial_ge};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DVD_W - 1)) begin
						state_q <= rbnh_pkg::S_FIX;
					end
				end
				rbnh_pkg::S_FIX: begin
					if (!sel_q) begin
						lo_q    <= t_val;
						dvd_q   <= {hi_mag, rbnh_pkg::DIR_FRAC'(0)};
						neg_q   <= num_hi_q[NUM_W-1] ^ d_ax[rbnh_pkg::DIR_W-1];
						rem_q   <= '0;
						step_q  <= '0;
						sel_q   <= 1'b1;
						state_q <= rbnh_pkg::S_DIV;
					end else begin
						tn_q   <= tn_new;
						tf_q   <= tf_new;
						have_q <= 1'b1;
						if (ax_q == rbnh_pkg::AX_Z) begin
							state_q <= rbnh_pkg::S_EVAL;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= rbnh_pkg::S_AXIS;
						end
					end
				end
				rbnh_pkg::S_EVAL: begin
					if (cube_ok) begin
						best_q     <= tn_q[rbnh_pkg::DIST_W-1:0];
						best_hit_q <= 1'b1;
						best_idx_q <= cnt_q[IDX_W-1:0];
						best_col_q <= rd_col_q;
					end
					if (cnt_q + 1'b1 >= n_q) begin
						state_q <= rbnh_pkg::S_DONE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= rbnh_pkg::S_FETCH;
					end
				end
				rbnh_pkg::S_DONE: begin
					res_valid_q <= 1'b1;
					res_hit_q   <= best_hit_q;
					res_idx_q   <= best_hit_q ? rbnh_pkg::SLOT_W'(best_idx_q) : '0;
					res_dist_q  <= best_q;
					res_col_q   <= best_hit_q ? best_col_q : '0;
					state_q     <= rbnh_pkg::S_IDLE;
				end
				default: state_q <= rbnh_pkg::S_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign hit          = res_hit_q;
	assign hit_index    = res_idx_q;
	assign hit_distance = res_dist_q;
	assign shade_red    = res_col_q[0 +: rbnh_pkg::COLOR_W];
	assign shade_green  = res_col_q[rbnh_pkg::COLOR_W +: rbnh_pkg::COLOR_W];
	assign shade_blue   = res_col_q[2*rbnh_pkg::COLOR_W +: rbnh_pkg::COLOR_W];

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe lasted more than one cycle");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !hit) |-> (hit_index == '0 && shade_red == '0 &&
		shade_green == '0 && shade_blue == '0))
		else $error("miss result carries slot or color");

	a_trace_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == rbnh_pkg::OP_TRACE) |=> busy)
		else $error("trace beat did not make the core busy");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == rbnh_pkg::OP_WRITE) |=> (!busy && !result_valid))
		else $error("write beat started work or gave a result");

endmodule

// ----- tb/tb_ray_box_nearest_hit_core.sv -----
// Self-checking testbench for ray_box_nearest_hit_core: directed and random trace
// and cube-write beats, checked against a nearest-hit slab-test predictor.
// Depends on rbnh_pkg and the core itself.
module tb_ray_box_nearest_hit_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCUBE = 8;

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
		logic [15:0] dval;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic operation = 1'b0;
	logic [2:0] entry_index = '0;
	logic signed [15:0] point_x = '0, point_y = '0, point_z = '0;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [7:0] paint_red = '0, paint_green = '0, paint_blue = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rbnh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rbnh_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic result_valid;
	logic hit;
	logic [2:0] hit_index;
	logic [15:0] hit_distance;
	logic [7:0] shade_red, shade_green, shade_blue;

	ray_box_nearest_hit_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .entry_index(entry_index),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.paint_red(paint_red), .paint_green(paint_green), .paint_blue(paint_blue),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .hit(hit),
		.hit_index(hit_index), .hit_distance(hit_distance),
		.shade_red(shade_red), .shade_green(shade_green), .shade_blue(shade_blue)
	);

	always #6 clk = ~clk;

	longint centers[NCUBE][3];
	logic [7:0] colors[NCUBE][3];
	logic [3:0] count_reg = rbnh_pkg::COUNT_RST;
	logic [14:0] half_reg = rbnh_pkg::HALF_RST;
	logic [15:0] bound_reg = rbnh_pkg::DIST_RST;
	shade_t expected_hits[$];
	int mismatches = 0;
	bit idling = 1'b1;

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
		return q;
	endfunction

	function automatic shade_t nearest_hit(longint p[3], longint d[3]);
		shade_t res;
		longint best, h, o, lo, hi, tn, tf;
		int n;
		bit have, pass;
		best = bound_reg;
		h = half_reg;
		n = (count_reg > NCUBE) ? NCUBE : count_reg;
		res = '0;
		for (int i = 0; i < n; i++) begin
			have = 0;
			pass = 1;
			tn = 0;
			tf = 0;
			for (int a = 0; a < 3; a++) begin
				o = p[a] - centers[i][a];
				if (d[a] == 0) begin
					if (o < -h || o > h) pass = 0;
				end else begin
					if (d[a] > 0) begin
						lo = floor_quot((-o - h) * 16384, d[a]);
						hi = floor_quot((-o + h) * 16384, d[a]);
					end else begin
						lo = floor_quot((h - o) * 16384, d[a]);
						hi = floor_quot((-o - h) * 16384, d[a]);
					end
					if (!have) begin
						tn = lo;
						tf = hi;
						have = 1;
					end else begin
						if (lo > tn) tn = lo;
						if (hi < tf) tf = hi;
					end
				end
			end
			if (!pass || !have || tn > tf || tf < 0) continue;
			if (tn > 0 && tn < best) begin
				best = tn;
				res.hit = 1;
				res.idx = 3'(i);
				res.r = colors[i][0];
				res.g = colors[i][1];
				res.b = colors[i][2];
			end
		end
		res.dval = best[15:0];
		return res;
	endfunction

	task automatic pause(int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_beat(rbnh_pkg::op_t op, logic [2:0] slot, logic [15:0] px,
			logic [15:0] py, logic [15:0] pz, logic [15:0] dx, logic [15:0] dy,
			logic [15:0] dz, logic [23:0] rgb);
		longint p[3], d[3];
		if (idling && $urandom_range(0, 3) == 0) pause($urandom_range(1, 14));
		operation = op;
		entry_index = slot;
		point_x = px; point_y = py; point_z = pz;
		dir_x = dx; dir_y = dy; dir_z = dz;
		{paint_red, paint_green, paint_blue} = rgb;
		start = 1'b1;
		do @(posedge clk); while (busy);
		p[0] = $signed(px); p[1] = $signed(py); p[2] = $signed(pz);
		d[0] = $signed(dx); d[1] = $signed(dy); d[2] = $signed(dz);
		if (op == rbnh_pkg::OP_WRITE) begin
			for (int a = 0; a < 3; a++) centers[slot][a] = p[a];
			{colors[slot][0], colors[slot][1], colors[slot][2]} = rgb;
		end else begin
			expected_hits.push_back(nearest_hit(p, d));
		end
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (expected_hits.size() != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(rbnh_pkg::cfg_reg_t idx, logic [15:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rbnh_pkg::REG_BOX_COUNT: count_reg = value[3:0];
			rbnh_pkg::REG_HALF_SIZE: half_reg = value[14:0];
			rbnh_pkg::REG_MAX_DIST:  bound_reg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(logic [3:0] cnt, logic [14:0] hs, logic [15:0] md);
		drain();
		write_reg(rbnh_pkg::REG_BOX_COUNT, {12'd0, cnt});
		write_reg(rbnh_pkg::REG_HALF_SIZE, {1'b0, hs});
		write_reg(rbnh_pkg::REG_MAX_DIST, md);
	endtask

	task automatic aimed_trace();
		int s;
		longint d[3], c, k;
		logic [15:0] o[3];
		s = $urandom_range(0, (count_reg == 0) ? NCUBE - 1 : ((count_reg > NCUBE) ?
			NCUBE - 1 : count_reg - 1));
		k = $urandom_range(0, 6000);
		for (int a = 0; a < 3; a++) begin
			d[a] = longint'($urandom_range(0, 32768)) - 16384;
			if ($urandom_range(0, 5) == 0) d[a] = 0;
			c = centers[s][a] - ((d[a] * k) >>> 14) +
				longint'($urandom_range(0, 2 * half_reg)) - half_reg;
			o[a] = c[15:0];
		end
		send_beat(rbnh_pkg::OP_TRACE, 3'($urandom), o[0], o[1], o[2], d[0][15:0],
			d[1][15:0], d[2][15:0], 24'($urandom));
	endtask

	task automatic noise_trace();
		logic [15:0] dv[3];
		for (int a = 0; a < 3; a++) begin
			dv[a] = 16'($urandom_range(0, 32768) - 16384);
			if ($urandom_range(0, 3) == 0) dv[a] = 0;
		end
		send_beat(rbnh_pkg::OP_TRACE, 3'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), dv[0], dv[1], dv[2], 24'($urandom));
	endtask

	task automatic random_write();
		send_beat(rbnh_pkg::OP_WRITE, 3'($urandom), 16'($urandom_range(0, 16000) - 8000),
			16'($urandom_range(0, 16000) - 8000), 16'($urandom_range(0, 16000) - 8000),
			16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
	endtask

	task automatic test_table_fill();
		for (int i = 0; i < NCUBE; i++)
			send_beat(rbnh_pkg::OP_WRITE, 3'(i), 16'(i * 512), 16'(-i * 256), 16'(i * 128),
				16'($urandom), 16'($urandom), 16'($urandom),
				{8'(i * 30), 8'(255 - i), 8'(i)});
		send_beat(rbnh_pkg::OP_WRITE, 3'd7, 16'h7fff, 16'h8000, 16'h7fff, '0, '0, '0,
			24'hffffff);
	endtask

	task automatic test_directed_rays();
		configure(4'd8, 15'd128, rbnh_pkg::DIST_RST);
		send_beat(rbnh_pkg::OP_TRACE, '0, -16'sd1024, 16'd0, 16'd0, 16'd16384, 16'd0,
			16'd0, '0);
		send_beat(rbnh_pkg::OP_TRACE, '0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, '0);
		send_beat(rbnh_pkg::OP_TRACE, '0, 16'd0, -16'sd2000, 16'd0, 16'd0, 16'd16384,
			16'd0, '0);
		send_beat(rbnh_pkg::OP_TRACE, '0, 16'd3000, 16'd0, 16'd0, -16'sd16384, 16'd0,
			16'd0, '0);
		send_beat(rbnh_pkg::OP_TRACE, '0, 16'h8000, 16'h7fff, 16'h8000, 16'd16384,
			-16'sd16384, 16'd16384, '0);
		send_beat(rbnh_pkg::OP_TRACE, '0, 16'h7fff, 16'h8000, 16'h7fff, -16'sd16384,
			16'd16384, -16'sd16384, '0);
		send_beat(rbnh_pkg::OP_TRACE, '0, 16'd200, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, '0);
		send_beat(rbnh_pkg::OP_TRACE, '0, 16'd0, 16'd0, -16'sd800, 16'd0, 16'd0,
			16'd11585, '0);
		configure(4'd15, 15'd32767, 16'hffff);
		send_beat(rbnh_pkg::OP_TRACE, '0, -16'sd20000, 16'd0, 16'd0, 16'd16384, 16'd1,
			16'd0, '0);
		configure(4'd2, 15'd1, 16'd0);
		send_beat(rbnh_pkg::OP_TRACE, '0, -16'sd1024, 16'd0, 16'd0, 16'd16384, 16'd0,
			16'd0, '0);
		configure(4'd0, 15'd256, 16'd1000);
		send_beat(rbnh_pkg::OP_TRACE, '0, -16'sd1024, 16'd0, 16'd0, 16'd16384, 16'd0,
			16'd0, '0);
	endtask

	task automatic test_random(int phases, int beats);
		logic [3:0] cnt;
		logic [14:0] hs;
		logic [15:0] md;
		int pick;
		for (int ph = 0; ph < phases; ph++) begin
			pick = $urandom_range(0, 9);
			cnt = (pick == 0) ? 4'd8 : (pick == 1) ? 4'($urandom_range(9, 15)) :
				(pick == 2) ? 4'd0 : 4'($urandom_range(1, 4));
			hs = ($urandom_range(0, 5) == 0) ? 15'($urandom_range(1, 32767)) :
				15'($urandom_range(32, 2048));
			md = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 65535));
			if (ph == phases - 1) idling = 1'b0;
			configure(cnt, hs, md);
			for (int i = 0; i < beats; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) random_write();
				else if (pick < 8) aimed_trace();
				else noise_trace();
			end
		end
	endtask

	always @(posedge clk) begin
		shade_t want, got;
		if (result_valid) begin
			got = {hit, hit_index, hit_distance, shade_red, shade_green, shade_blue};
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
			end else begin
				want = expected_hits.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected hit %b idx %0d dist %0d ",
							want.hit, want.idx, want.dval,
							"rgb %h%h%h, got hit %b idx %0d dist %0d rgb %h%h%h",
							want.r, want.g, want.b,
							got.hit, got.idx, got.dval, got.r, got.g, got.b);
				end
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_table_fill();
		test_directed_rays();
		test_random(8, 110);
		drain();
		if (mismatches == 0 && expected_hits.size() == 0) begin
			$display("ray_box_nearest_hit_core regression: pass");
		end else begin
			$display("ray_box_nearest_hit_core regression: fail");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("ray_box_nearest_hit_core regression: fail");
		$finish;
	end
endmodule
